### rtl/core/sparse_column_slice_remap_defines.svh
// Assertion macros used by the checker of the sparse column slice remapper.
`ifndef SPARSE_COLUMN_SLICE_REMAP_DEFINES_SVH
`define SPARSE_COLUMN_SLICE_REMAP_DEFINES_SVH

// Same-cycle implication, sampled on clock and switched off while reset is high.
`define SCSR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and switched off while reset is high.
`define SCSR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/scsr_pkg.sv
// Package of the sparse column slice remapper: field widths and register indexes.
`default_nettype none

package scsr_pkg;

   localparam int COL_BITS     = 24;
   localparam int SCALAR_BITS  = 27;
   localparam int TOTAL_BITS   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int CNT_REG_W    = 3;
   localparam int SUBW_REG_W   = 4;
   localparam int PTR_W        = 3;
   localparam int NUM_IV_REGS  = 4;

   // Result beat: local_col, scalar_col, row_pos, total_kept, padded to bytes.
   localparam int RSP_FIELD_W  = COL_BITS + 2 * SCALAR_BITS + TOTAL_BITS;
   localparam int RSP_TDATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int REQ_TDATA_W  = ((COL_BITS + 7) / 8) * 8;

   localparam int LOCAL_LSB    = 0;
   localparam int SCALAR_LSB   = LOCAL_LSB + COL_BITS;
   localparam int ROW_LSB      = SCALAR_LSB + SCALAR_BITS;
   localparam int TOTAL_LSB    = ROW_LSB + SCALAR_BITS;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INTERVAL_0     = 3'd0,
      CSR_INTERVAL_1     = 3'd1,
      CSR_INTERVAL_2     = 3'd2,
      CSR_INTERVAL_3     = 3'd3,
      CSR_INTERVAL_COUNT = 3'd4,
      CSR_SUB_WIDTH      = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/core/sparse_column_slice_remap.sv
// Top level of the sparse column slice remapper: interval walk and lane expansion.
`default_nettype none

// Sparse column slice remapper.
// The request channel carries one block-column index per beat, ascending within a row;
// req_tuser marks the first nonzero of a new row. Each column is checked against up to
// four ascending half-open column intervals, walked by an interval pointer that never
// moves back. A kept column is renumbered with the skipped gaps removed and expanded into
// sub_width response beats, one per lane; a discarded column gives a single beat with
// rsp_tuser (kept) low. rsp_tlast marks the final beat caused by one request beat.
// On request acceptance the interval walk updates the row state and loads the hold stage;
// the lane multiply then fills the output register from the hold stage. A kept column takes
// one beat of the output port per lane, that is sub_width with zero read as one and values
// above MAX_SUB_WIDTH clipped to it; a discarded column takes one beat. While the receiver
// takes every beat the block sustains one beat per cycle, and a new request is taken as the
// final lane of the previous one leaves the hold stage. The lane counter in the hold stage
// marks that final lane. A synchronous reset empties both stages, clears the row state and
// the kept total and returns the registers to their reset values. When the receiver stalls,
// the output beat holds, the hold stage waits and req_tready falls once the hold stage
// cannot drain. Configuration is written through csr_we, csr_addr and csr_wdata; the user
// must do so only while the block is idle, which the block itself does not enforce.
module sparse_column_slice_remap #(
   parameter int MAX_INTERVALS = 4,
   parameter int MAX_SUB_WIDTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request: tdata[23:0] col; tuser[0] row_start.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [scsr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tuser,
   // Response: tdata[23:0] local_col, [50:24] scalar_col, [77:51] row_pos,
   // [109:78] total_kept, [111:110] zero; tuser[0] kept; tlast last.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [scsr_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   // Register write port.
   input  wire logic                                 csr_we,
   input  wire logic [scsr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [scsr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import scsr_pkg::*;

   // Interval registers actually held; the pointer stops at most one past the last interval in use.
   localparam int NIV   = (MAX_INTERVALS < NUM_IV_REGS) ? MAX_INTERVALS : NUM_IV_REGS;
   localparam int CNT_W = $clog2(MAX_SUB_WIDTH + 1);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] iv_ff [NIV];
   logic [CNT_REG_W-1:0]  count_ff;
   logic [SUBW_REG_W-1:0] subw_ff;

   // Row and running state.
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [COL_BITS-1:0]   gap_ff, gap_in;
   logic [COL_BITS-1:0]   rk_ff, rk_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;

   // Hold stage: one decided column waiting to be expanded into lanes.
   logic                  hold_valid_ff;
   logic                  hold_kept_ff;
   logic [COL_BITS-1:0]   hold_local_ff;
   logic [COL_BITS-1:0]   hold_base_ff;
   logic [TOTAL_BITS-1:0] hold_total_ff;
   logic [CNT_W-1:0]      hold_w_ff;
   logic [CNT_W-1:0]      lane_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_kept_ff;
   logic                   rsp_last_ff;
   logic [COL_BITS-1:0]    rsp_local_ff;
   logic [SCALAR_BITS-1:0] rsp_scalar_ff;
   logic [SCALAR_BITS-1:0] rsp_row_ff;
   logic [TOTAL_BITS-1:0]  rsp_total_ff;

   // Decision logic.
   logic [COL_BITS-1:0]   col;
   logic [CNT_REG_W-1:0]  n_act;
   logic [CNT_W-1:0]      w_lanes;
   logic [PTR_W-1:0]      p0;
   logic [COL_BITS-1:0]   gap0;
   logic [COL_BITS-1:0]   rk0;
   logic [COL_BITS-1:0]   end_cur;
   logic [COL_BITS-1:0]   first_sel;
   logic                  advance;
   logic                  found;
   logic                  keep;

   // Handshake and lane logic.
   logic                  accept;
   logic                  out_load;
   logic                  emit;
   logic                  hold_last;
   logic [31:0]           scalar_full;
   logic [31:0]           row_full;

   assign col = req_tdata[COL_BITS-1:0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NIV; j++) begin
            iv_ff[j] <= '0;
         end
         count_ff <= CNT_REG_W'(1);
         subw_ff  <= SUBW_REG_W'(1);
      end else if (csr_we) begin
         for (int j = 0; j < NIV; j++) begin
            if (csr_addr == CSR_ADDR_W'(CSR_INTERVAL_0) + CSR_ADDR_W'(j)) begin
               iv_ff[j] <= csr_wdata;
            end
         end
         if (csr_addr == CSR_INTERVAL_COUNT) begin
            count_ff <= csr_wdata[CNT_REG_W-1:0];
         end
         if (csr_addr == CSR_SUB_WIDTH) begin
            subw_ff <= csr_wdata[SUBW_REG_W-1:0];
         end
      end
   end

   // Intervals in use and lanes per kept column, both clipped to what is built; a zero sub_width reads as one.
   always_comb begin
      n_act = count_ff;
      if (count_ff > CNT_REG_W'(NIV)) begin
         n_act = CNT_REG_W'(NIV);
      end
      if (subw_ff == '0) begin
         w_lanes = CNT_W'(1);
      end else if (int'(subw_ff) > MAX_SUB_WIDTH) begin
         w_lanes = CNT_W'(MAX_SUB_WIDTH);
      end else begin
         w_lanes = CNT_W'(subw_ff);
      end
   end

   // Interval walk. A row start restarts the pointer and loads the gap with the first
   // column of the lowest interval. When the column lies at or beyond the end of the
   // current interval, the pointer moves up, adding each gap between intervals passed; it stops
   // at the first interval whose end lies above the column, else past the last one in use.
   always_comb begin
      p0   = req_tuser ? '0 : ptr_ff;
      gap0 = req_tuser ? iv_ff[0][COL_BITS-1:0] : gap_ff;
      rk0  = req_tuser ? '0 : rk_ff;

      end_cur = '0;
      for (int j = 0; j < NIV; j++) begin
         if (p0 == PTR_W'(j)) begin
            end_cur = iv_ff[j][2*COL_BITS-1:COL_BITS];
         end
      end
      advance = (p0 < PTR_W'(n_act)) && (col >= end_cur);

      ptr_in = p0;
      gap_in = gap0;
      found  = 1'b0;
      if (advance) begin
         ptr_in = PTR_W'(n_act);
         for (int j = 1; j < NIV; j++) begin
            if (!found && (p0 < PTR_W'(j)) && (PTR_W'(j) < PTR_W'(n_act))) begin
               gap_in = gap_in + iv_ff[j][COL_BITS-1:0]
                        - iv_ff[j-1][2*COL_BITS-1:COL_BITS];
               if (col < iv_ff[j][2*COL_BITS-1:COL_BITS]) begin
                  ptr_in = PTR_W'(j);
                  found  = 1'b1;
               end
            end
         end
      end

      first_sel = '0;
      for (int j = 0; j < NIV; j++) begin
         if (ptr_in == PTR_W'(j)) begin
            first_sel = iv_ff[j][COL_BITS-1:0];
         end
      end
      keep = (ptr_in < PTR_W'(n_act)) && (col >= first_sel);

      rk_in    = keep ? rk0 + COL_BITS'(1) : rk0;
      total_in = (keep && (total_ff != '1)) ? total_ff + TOTAL_BITS'(1) : total_ff;
   end

   // Handshake. The hold stage drains one lane into the output register per cycle while that
   // register can load; a new request enters as its final lane leaves.
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign emit       = hold_valid_ff && out_load;
   assign hold_last  = !hold_kept_ff || (lane_ff == hold_w_ff - CNT_W'(1));
   assign req_tready = !hold_valid_ff || (emit && hold_last);
   assign accept     = req_tvalid && req_tready;

   // Row state is committed as the request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         gap_ff   <= '0;
         rk_ff    <= '0;
         total_ff <= '0;
      end else if (accept) begin
         ptr_ff   <= ptr_in;
         gap_ff   <= gap_in;
         rk_ff    <= rk_in;
         total_ff <= total_in;
      end
   end

   // Hold stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         lane_ff       <= '0;
      end else if (accept) begin
         hold_valid_ff <= 1'b1;
         lane_ff       <= '0;
      end else if (emit && hold_last) begin
         hold_valid_ff <= 1'b0;
      end else if (emit) begin
         lane_ff <= lane_ff + CNT_W'(1);
      end
   end

   // Hold stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_kept_ff  <= keep;
         hold_local_ff <= col - gap_in;
         hold_base_ff  <= rk0;
         hold_total_ff <= total_in;
         hold_w_ff     <= w_lanes;
      end
   end

   // Lane expansion: scalar column and position within the destination row.
   assign scalar_full = 32'(hold_local_ff) * 32'(hold_w_ff) + 32'(lane_ff);
   assign row_full    = 32'(hold_base_ff) * 32'(hold_w_ff) + 32'(lane_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kept_ff   <= hold_kept_ff;
         rsp_last_ff   <= hold_last;
         rsp_total_ff  <= hold_total_ff;
         rsp_local_ff  <= hold_kept_ff ? hold_local_ff : '0;
         rsp_scalar_ff <= hold_kept_ff ? scalar_full[SCALAR_BITS-1:0] : '0;
         rsp_row_ff    <= hold_kept_ff ? row_full[SCALAR_BITS-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kept_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}},
                        rsp_total_ff, rsp_row_ff, rsp_scalar_ff, rsp_local_ff};

endmodule

`default_nettype wire

### rtl/core/scsr_checker.sv
// Port-level checker of the sparse column slice remapper, bound to its top level.
`default_nettype none

`include "sparse_column_slice_remap_defines.svh"

module scsr_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [scsr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input wire logic                                 req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [scsr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input wire logic                                 rsp_tuser,
   input wire logic                                 rsp_tlast,
   input wire logic                                 csr_we,
   input wire logic [scsr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input wire logic [scsr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import scsr_pkg::*;

   logic [COL_BITS-1:0]    out_local;
   logic [SCALAR_BITS-1:0] out_scalar;
   logic [SCALAR_BITS-1:0] out_row;
   logic                   req_seen;
   logic                   csr_seen;

   assign out_local  = rsp_tdata[LOCAL_LSB +: COL_BITS];
   assign out_scalar = rsp_tdata[SCALAR_LSB +: SCALAR_BITS];
   assign out_row    = rsp_tdata[ROW_LSB +: SCALAR_BITS];
   assign req_seen   = req_tvalid && req_tready && (req_tdata != '0 || req_tuser);
   assign csr_seen   = csr_we && (csr_addr != '0 || csr_wdata != '0);

   // A stalled response beat holds its payload.
   `SCSR_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled response beat changed")

   // A discarded column gives one closing beat with zero column fields.
   `SCSR_ASSERT_IMP(a_discard_beat, rsp_tvalid && !rsp_tuser, rsp_tlast && out_local == '0 && out_scalar == '0 && out_row == '0, "discard beat malformed")

   // Lanes of one kept column follow each other back to back with rising lane index.
   `SCSR_ASSERT_NXT(a_lane_step, rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast, rsp_tvalid && rsp_tuser && out_local == $past(out_local) && out_scalar == SCALAR_BITS'($past(out_scalar) + SCALAR_BITS'(1)) && out_row == SCALAR_BITS'($past(out_row) + SCALAR_BITS'(1)), "lane sequence broken")

   // The output register is empty right after reset.
   `SCSR_ASSERT_IMP(a_reset_empty, $past(reset) && !$past(req_seen) && !$past(csr_seen), !rsp_tvalid, "response valid after reset")

endmodule

bind sparse_column_slice_remap scsr_checker u_scsr_checker (.*);

`default_nettype wire
